### hdl/cdsb_pkg.sv
// Package: shared constants and helpers for the column distinct-state bound block.
package cdsb_pkg;

  localparam int STATE_LIMIT_DEF = 8;
  localparam int SUM_WIDTH_DEF   = 24;
  localparam int SYM_W           = 8;

  localparam logic [SYM_W-1:0] SYM_GAP     = 8'h2D;  // '-'
  localparam logic [SYM_W-1:0] SYM_UNKNOWN = 8'h3F;  // '?'
  localparam logic [SYM_W-1:0] SYM_ANY_N   = 8'h4E;  // 'N'
  localparam logic [SYM_W-1:0] SYM_ANY_X   = 8'h58;  // 'X'

  typedef logic [SYM_W-1:0] sym_t;

  function automatic logic is_ignored(input sym_t s);
    return (s == SYM_GAP) || (s == SYM_UNKNOWN) || (s == SYM_ANY_N) || (s == SYM_ANY_X);
  endfunction

endpackage

### hdl/cdsb_cell.sv
// One storage cell: holds a seen symbol, compares it to the probe, shifts to its neighbor.
module cdsb_cell
  import cdsb_pkg::*;
(
  input  logic clk,
  input  logic shift_en,
  input  sym_t sym_in,
  input  sym_t probe,
  input  logic active,
  output sym_t sym_out,
  output logic hit
);

  sym_t sym_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      sym_r <= sym_in;
    end
  end

  assign sym_out = sym_r;
  assign hit     = active && (sym_r == probe);

endmodule

### hdl/cdsb_chain.sv
// Row of symbol cells: newest symbol enters cell 0, older ones move one cell down.
module cdsb_chain
  import cdsb_pkg::*;
#(
  parameter int STATE_LIMIT = STATE_LIMIT_DEF,
  localparam int TOT_W = $clog2(STATE_LIMIT + 1)
) (
  input  logic             clk,
  input  logic             insert,
  input  sym_t             probe,
  input  logic [TOT_W-1:0] total,
  output logic             hit
);

  sym_t                   sym_chain [STATE_LIMIT];
  logic [STATE_LIMIT-1:0] hit_vec;

  for (genvar i = 0; i < STATE_LIMIT; i++) begin : g_cell
    sym_t cell_in;
    logic cell_active;

    if (i == 0) begin : g_head
      assign cell_in = probe;
    end else begin : g_body
      assign cell_in = sym_chain[i-1];
    end

    // entries below the fill count hold valid symbols
    assign cell_active = (total > TOT_W'(i));

    cdsb_cell u_cell (
      .clk      (clk),
      .shift_en (insert),
      .sym_in   (cell_in),
      .probe    (probe),
      .active   (cell_active),
      .sym_out  (sym_chain[i]),
      .hit      (hit_vec[i])
    );
  end

  assign hit = |hit_vec;

endmodule

### hdl/column_distinct_state_bound.sv
// A result appears in the output register in the cycle after its column-end transaction is accepted.
// Throughput: one symbol per cycle while the output register is empty or read; the cell row compares a symbol
// against all stored symbols in the cycle it arrives, and in_tready drops while a result waits and out_tready is low.
// Reset (rst_n low, synchronous): fill count, overflow flag, running sum and output valid clear;
// stored cell symbols are not reset and are read only below the fill count.
// Top level: per-column distinct symbol count and saturating minimum-length bound.
module column_distinct_state_bound
  import cdsb_pkg::*;
#(
  parameter int STATE_LIMIT = STATE_LIMIT_DEF,
  parameter int SUM_WIDTH   = SUM_WIDTH_DEF,
  localparam int TOT_W  = $clog2(STATE_LIMIT + 1),
  localparam int OUT_DW = ((2 * TOT_W + SUM_WIDTH + 1 + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // symbol[7:0]
  input  logic              in_tlast,   // column_end
  input  logic              in_tuser,   // matrix_end
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // distinct_count, overflowed, column_contribution,
                                        // running_bound, zero pad
  output logic              out_tlast   // final_res
);

  localparam logic [TOT_W-1:0]     LIMIT_V = TOT_W'(STATE_LIMIT);
  localparam logic [SUM_WIDTH-1:0] SUM_MAX = {SUM_WIDTH{1'b1}};

  logic [TOT_W-1:0]     total_r, total_nxt;
  logic                 exc_r, exc_nxt;
  logic [SUM_WIDTH-1:0] sum_r, sum_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [TOT_W-1:0]     cnt_r, cnt_nxt;
  logic                 ovf_r;
  logic [TOT_W-1:0]     contrib_r, contrib_nxt;
  logic [SUM_WIDTH-1:0] bound_r, bound_nxt;
  logic                 final_r;

  logic                 in_acc;
  logic                 hit;
  logic                 new_sym;
  logic                 full;
  logic                 insert;
  logic [TOT_W-1:0]     tot_upd;
  logic                 exc_upd;
  logic [SUM_WIDTH:0]   sum_ext;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  cdsb_chain #(.STATE_LIMIT(STATE_LIMIT)) u_chain (
    .clk    (clk),
    .insert (insert),
    .probe  (in_tdata),
    .total  (total_r),
    .hit    (hit)
  );

  always_comb begin
    new_sym = !exc_r && !is_ignored(in_tdata) && !hit;
    full    = (total_r == LIMIT_V);
    insert  = in_acc && new_sym && !full;
    tot_upd = (new_sym && !full) ? total_r + TOT_W'(1) : total_r;
    exc_upd = exc_r || (new_sym && full);

    if (exc_upd) begin
      cnt_nxt     = LIMIT_V;
      contrib_nxt = LIMIT_V;
    end else begin
      cnt_nxt     = tot_upd;
      contrib_nxt = (tot_upd == '0) ? '0 : tot_upd - TOT_W'(1);
    end

    sum_ext   = {1'b0, sum_r} + (SUM_WIDTH + 1)'(contrib_nxt);
    bound_nxt = sum_ext[SUM_WIDTH] ? SUM_MAX : sum_ext[SUM_WIDTH-1:0];

    total_nxt     = total_r;
    exc_nxt       = exc_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (in_acc) begin
      if (in_tlast) begin
        total_nxt     = '0;
        exc_nxt       = 1'b0;
        sum_nxt       = in_tuser ? '0 : bound_nxt;
        out_valid_nxt = 1'b1;
      end else begin
        total_nxt = tot_upd;
        exc_nxt   = exc_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      exc_r       <= 1'b0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      total_r     <= total_nxt;
      exc_r       <= exc_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_tlast) begin
      cnt_r     <= cnt_nxt;
      ovf_r     <= exc_upd;
      contrib_r <= contrib_nxt;
      bound_r   <= bound_nxt;
      final_r   <= in_tuser;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DW'({bound_r, contrib_r, ovf_r, cnt_r});
  assign out_tlast  = final_r;

endmodule

### hdl/cdsb_checker.sv
// Port-level checker for the column distinct-state bound block, bound to the top level.
module cdsb_checker
  import cdsb_pkg::*;
#(
  parameter int STATE_LIMIT = STATE_LIMIT_DEF,
  parameter int SUM_WIDTH   = SUM_WIDTH_DEF,
  localparam int TOT_W  = $clog2(STATE_LIMIT + 1),
  localparam int OUT_DW = ((2 * TOT_W + SUM_WIDTH + 1 + 7) / 8) * 8
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic [7:0]        in_tdata,
  input logic              in_tlast,
  input logic              in_tuser,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_DW-1:0] out_tdata,
  input logic              out_tlast
);

  logic [TOT_W-1:0] chk_cnt, chk_contrib;
  logic             chk_ovf;

  assign chk_cnt     = out_tdata[TOT_W-1:0];
  assign chk_ovf     = out_tdata[TOT_W];
  assign chk_contrib = out_tdata[2*TOT_W:TOT_W+1];

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_free: assert property (@(posedge clk) disable iff (!rst_n) !out_tvalid |-> in_tready)
    else $error("input stalled with empty output register");

  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && chk_ovf |->
      chk_cnt == TOT_W'(STATE_LIMIT) && chk_contrib == TOT_W'(STATE_LIMIT))
    else $error("overflow result does not report the limit");

  a_contrib: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !chk_ovf |->
      chk_contrib == ((chk_cnt == '0) ? '0 : chk_cnt - TOT_W'(1)))
    else $error("contribution is not count minus one");

endmodule

bind column_distinct_state_bound cdsb_checker #(
  .STATE_LIMIT (STATE_LIMIT),
  .SUM_WIDTH   (SUM_WIDTH)
) u_cdsb_checker (.*);
